// File: rtl/midi_note_to_pad_map_table_macros.svh
// assertion macros for the note-to-pad map table
`ifndef MIDI_NOTE_TO_PAD_MAP_TABLE_MACROS_SVH
`define MIDI_NOTE_TO_PAD_MAP_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MNPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MNPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MNPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MNPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/mnpm_pkg.sv
package mnpm_pkg;

    localparam int ENTRIES    = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int DFLT_COUNT = 24;
    localparam int MAIN_PADS  = 16;
    localparam int TCOUNT_W   = 6;

    localparam logic [2:0] REQ_LOOKUP   = 3'd0;
    localparam logic [2:0] REQ_SET_NOTE = 3'd1;
    localparam logic [2:0] REQ_SET_PAD  = 3'd2;
    localparam logic [2:0] REQ_CLEAR    = 3'd3;
    localparam logic [2:0] REQ_RESTORE  = 3'd4;
    localparam logic [2:0] REQ_READ     = 3'd5;

    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_APPEND  = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic signed [4:0] PAD_NONE = -5'sd1;

    typedef struct packed {
        logic [6:0]        note;
        logic signed [4:0] pad;
        logic              en;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             restore;
    } t_mem_req;

    localparam logic [6:0] DFLT_NOTE [DFLT_COUNT] = '{
        7'd36, 7'd38, 7'd42, 7'd46, 7'd49, 7'd39, 7'd37, 7'd56,
        7'd41, 7'd47, 7'd50, 7'd70, 7'd75, 7'd62, 7'd63, 7'd64,
        7'd35, 7'd40, 7'd44, 7'd51, 7'd57, 7'd59, 7'd43, 7'd45
    };

    localparam logic signed [4:0] DFLT_PAD [DFLT_COUNT] = '{
        5'sd0, 5'sd1, 5'sd2,  5'sd3,  5'sd4,  5'sd5,  5'sd6,  5'sd7,
        5'sd8, 5'sd9, 5'sd10, 5'sd11, 5'sd12, 5'sd13, 5'sd14, 5'sd15,
        5'sd0, 5'sd1, 5'sd2,  5'sd4,  5'sd4,  5'sd4,  5'sd8,  5'sd9
    };

    function automatic t_entry dflt_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        e.note = 7'd0;
        e.pad  = PAD_NONE;
        e.en   = 1'b0;
        if (int'(idx) < DFLT_COUNT) begin
            e.note = DFLT_NOTE[idx];
            e.pad  = DFLT_PAD[idx];
            e.en   = 1'b1;
        end
        return e;
    endfunction

endpackage

// File: rtl/mnpm_ram.sv
module mnpm_ram #(
    parameter int  DEPTH = 32,
    parameter int  WIDTH = 13,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_re,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// File: rtl/mnpm_ctrl.sv
`include "midi_note_to_pad_map_table_macros.svh"

module mnpm_ctrl import mnpm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_req_type,
    input  logic [6:0]        i_note_in,
    input  logic signed [4:0] i_pad_in,
    input  logic [4:0]        i_entry_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [4:0] o_pad_out,
    output logic [1:0]        o_status,
    output logic [6:0]        o_entry_note,
    output logic signed [4:0] o_entry_pad,
    output logic              o_entry_enabled,
    output logic [TCOUNT_W-1:0] o_table_count,
    output logic              o_changed,
    output t_mem_req          o_mem,
    input  t_entry            i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_RDCAP,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_req;
    logic [6:0]        r_note;
    logic signed [4:0] r_pad;
    logic [4:0]        r_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_addr;
    logic              r_chk;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_nt_hit, r_lk_hit, r_pd_hit;
    logic [IDX_W-1:0]  r_nt_idx, r_pd_idx;
    logic signed [4:0] r_nt_pad, r_lk_pad;
    t_entry            r_rd_entry;

    logic              r_out_valid;
    logic signed [4:0] r_pad_out;
    logic [1:0]        r_status;
    logic [6:0]        r_e_note;
    logic signed [4:0] r_e_pad;
    logic              r_e_en;
    logic [TCOUNT_W-1:0] r_tcount;
    logic              r_changed;

    logic              accept, issue, go, idx_ok, in_idx_ok, room;
    logic              wr_want, restore_want;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic signed [4:0] res_pad_out;
    logic [1:0]        res_status;
    logic [6:0]        res_e_note;
    logic signed [4:0] res_e_pad;
    logic              res_e_en;
    logic              res_changed;
    logic [CNT_W-1:0]  res_count;
    logic              note_eq, pad_eq, in_main;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign issue     = (r_state == S_SCAN) && (r_addr < r_count);
    assign go        = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign idx_ok    = CNT_W'(r_idx) < r_count;
    assign in_idx_ok = CNT_W'(i_entry_index) < r_count;
    assign room      = r_count < CNT_W'(ENTRIES);

    assign note_eq = i_rd_data.note == r_note;
    assign pad_eq  = i_rd_data.pad == r_pad;
    assign in_main = CNT_W'(r_chk_idx) < CNT_W'(MAIN_PADS);

    // result of the finished request
    always_comb begin
        wr_want      = 1'b0;
        restore_want = 1'b0;
        wr_addr      = r_nt_idx;
        wr_data.note = r_note;
        wr_data.pad  = r_pad;
        wr_data.en   = !r_pad[4];
        res_pad_out  = PAD_NONE;
        res_status   = ST_NOMATCH;
        res_e_note   = 7'd0;
        res_e_pad    = PAD_NONE;
        res_e_en     = 1'b0;
        res_changed  = 1'b0;
        res_count    = r_count;
        unique case (r_req) inside
            REQ_LOOKUP: begin
                if (r_lk_hit) begin
                    res_pad_out = r_lk_pad;
                    res_status  = ST_HIT;
                end
            end
            REQ_SET_NOTE, REQ_SET_PAD: begin
                if (r_req == REQ_SET_PAD && r_pd_hit) begin
                    wr_want     = 1'b1;
                    wr_addr     = r_pd_idx;
                    wr_data.en  = 1'b1;
                    res_status  = ST_HIT;
                    res_changed = 1'b1;
                end else if (r_nt_hit) begin
                    wr_want     = 1'b1;
                    res_status  = ST_HIT;
                    res_changed = 1'b1;
                end else if (room) begin
                    wr_want     = 1'b1;
                    wr_addr     = IDX_W'(r_count);
                    res_status  = ST_APPEND;
                    res_changed = 1'b1;
                    res_count   = r_count + CNT_W'(1);
                end else begin
                    res_status  = ST_FULL;
                end
            end
            REQ_CLEAR: begin
                if (r_nt_hit) begin
                    wr_want     = 1'b1;
                    wr_data.pad = r_nt_pad;
                    wr_data.en  = 1'b0;
                    res_status  = ST_HIT;
                    res_changed = 1'b1;
                end
            end
            REQ_RESTORE: begin
                restore_want = 1'b1;
                res_status   = ST_HIT;
                res_changed  = 1'b1;
                res_count    = CNT_W'(DFLT_COUNT);
            end
            REQ_READ: begin
                if (idx_ok) begin
                    res_e_note = r_rd_entry.note;
                    res_e_pad  = r_rd_entry.pad;
                    res_e_en   = r_rd_entry.en;
                    res_status = ST_HIT;
                end
            end
            default: begin
                res_status = ST_NOMATCH;
            end
        endcase
    end

    always_comb begin
        o_mem.rd_en   = issue || (r_state == S_RD);
        o_mem.rd_addr = (r_state == S_RD) ? IDX_W'(r_idx) : r_addr[IDX_W-1:0];
        o_mem.wr_en   = go && wr_want;
        o_mem.wr_addr = wr_addr;
        o_mem.wr_data = wr_data;
        o_mem.restore = go && restore_want;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type) inside
                        REQ_LOOKUP, REQ_SET_NOTE, REQ_SET_PAD, REQ_CLEAR: begin
                            n_state = (r_count == '0) ? S_DONE : S_SCAN;
                        end
                        REQ_READ: begin
                            n_state = in_idx_ok ? S_RD : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!issue) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_RDCAP;
            end
            S_RDCAP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (go) begin
                    n_state = S_IDLE;
                    n_count = res_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(DFLT_COUNT);
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chk   <= issue;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (accept) begin
            r_req    <= i_req_type;
            r_note   <= i_note_in;
            r_pad    <= i_pad_in;
            r_idx    <= i_entry_index;
            r_addr   <= '0;
            r_nt_hit <= 1'b0;
            r_lk_hit <= 1'b0;
            r_pd_hit <= 1'b0;
        end

        if (issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end
        r_chk_idx <= r_addr[IDX_W-1:0];

        // first-match capture on returning read data
        if (r_state == S_SCAN && r_chk) begin
            if (note_eq && !r_nt_hit) begin
                r_nt_hit <= 1'b1;
                r_nt_idx <= r_chk_idx;
                r_nt_pad <= i_rd_data.pad;
            end
            if (note_eq && i_rd_data.en && !r_lk_hit) begin
                r_lk_hit <= 1'b1;
                r_lk_pad <= i_rd_data.pad;
            end
            if (pad_eq && in_main && !r_pd_hit) begin
                r_pd_hit <= 1'b1;
                r_pd_idx <= r_chk_idx;
            end
        end

        if (r_state == S_RDCAP) begin
            r_rd_entry <= i_rd_data;
        end

        if (go) begin
            r_pad_out <= res_pad_out;
            r_status  <= res_status;
            r_e_note  <= res_e_note;
            r_e_pad   <= res_e_pad;
            r_e_en    <= res_e_en;
            r_tcount  <= TCOUNT_W'(res_count);
            r_changed <= res_changed;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_pad_out       = r_pad_out;
    assign o_status        = r_status;
    assign o_entry_note    = r_e_note;
    assign o_entry_pad     = r_e_pad;
    assign o_entry_enabled = r_e_en;
    assign o_table_count   = r_tcount;
    assign o_changed       = r_changed;

    `MNPM_ASSERT_IMP(a_no_rd_wr_overlap, i_clk, i_rst_n, o_mem.wr_en, !o_mem.rd_en, "read and write in one cycle")
    `MNPM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(ENTRIES), "fill count overflow")
    `MNPM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE, "accepted transaction not started")
    `MNPM_ASSERT_IMP(a_count_at_done, i_clk, i_rst_n, n_count != r_count, go, "fill count changed outside completion")
    `MNPM_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, go, r_out_valid, "completed transaction not presented")

endmodule

// File: rtl/midi_note_to_pad_map_table.sv
// lookup, set by note, set by pad, clear: walk the first count entries, then the result
// read entry: S_RD, S_RDCAP, then the result (straight to it when the index is past the count)
// restore and unused codes: straight to the result; one transaction at a time, held by the
// linear walk of the entry memory; next transaction is taken once the result is out
// reset: fill count 24, drum defaults served from a per-entry default overlay, no clearing pass
module midi_note_to_pad_map_table import mnpm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_req_type,
    input  logic [6:0]        i_note_in,
    input  logic signed [4:0] i_pad_in,
    input  logic [4:0]        i_entry_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [4:0] o_pad_out,
    output logic [1:0]        o_status,
    output logic [6:0]        o_entry_note,
    output logic signed [4:0] o_entry_pad,
    output logic              o_entry_enabled,
    output logic [5:0]        o_table_count,
    output logic              o_changed
);

    t_mem_req              mem;
    logic [ENTRY_W-1:0]    ram_q;
    logic [ENTRIES-1:0]    r_written;
    logic [IDX_W-1:0]      r_rd_addr;
    t_entry                rd_data;

    mnpm_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_re      (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (ram_q)
    );

    // entries not written since reset or restore read as the defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (mem.restore) begin
            r_written <= '0;
        end else if (mem.wr_en) begin
            r_written[mem.wr_addr] <= 1'b1;
        end
        if (mem.rd_en) begin
            r_rd_addr <= mem.rd_addr;
        end
    end

    assign rd_data = r_written[r_rd_addr] ? t_entry'(ram_q) : dflt_entry(r_rd_addr);

    mnpm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_note_in       (i_note_in),
        .i_pad_in        (i_pad_in),
        .i_entry_index   (i_entry_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pad_out       (o_pad_out),
        .o_status        (o_status),
        .o_entry_note    (o_entry_note),
        .o_entry_pad     (o_entry_pad),
        .o_entry_enabled (o_entry_enabled),
        .o_table_count   (o_table_count),
        .o_changed       (o_changed),
        .o_mem           (mem),
        .i_rd_data       (rd_data)
    );

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import mnpm_pkg::*;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int RANDOM_REQS = 500;
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]        req;
        logic [6:0]        note;
        logic signed [4:0] pad;
        logic [4:0]        idx;
        int                gap;
        bit                drain;
    } t_map_req;

    typedef struct {
        logic signed [4:0] pad;
        logic [1:0]        status;
        logic [6:0]        e_note;
        logic signed [4:0] e_pad;
        logic              e_en;
        logic [5:0]        count;
        logic              chg;
    } t_map_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    logic [2:0]        in_req = '0;
    logic [6:0]        in_note = '0;
    logic signed [4:0] in_pad = '0;
    logic [4:0]        in_idx = '0;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    logic signed [4:0] o_pad_out;
    logic [1:0]        o_status;
    logic [6:0]        o_entry_note;
    logic signed [4:0] o_entry_pad;
    logic              o_entry_enabled;
    logic [5:0]        o_table_count;
    logic              o_changed;

    t_entry      pad_map [ENTRIES];
    int unsigned map_fill;

    t_map_req    pending_reqs [$];
    t_map_reply  expected_replies [$];

    int  n_put = 0;
    int  n_got = 0;
    int  n_err = 0;
    int  cycles = 0;
    int  wait_cnt = 0;
    int  hold_left = 0;
    bit  tx_done;
    bit  tx_calm = 0;
    bit  rx_calm = 0;

    midi_note_to_pad_map_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (in_req),
        .i_note_in       (in_note),
        .i_pad_in        (in_pad),
        .i_entry_index   (in_idx),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_pad_out       (o_pad_out),
        .o_status        (o_status),
        .o_entry_note    (o_entry_note),
        .o_entry_pad     (o_entry_pad),
        .o_entry_enabled (o_entry_enabled),
        .o_table_count   (o_table_count),
        .o_changed       (o_changed)
    );

    always #6 i_clk = ~i_clk;

    function automatic void reset_map();
        for (int i = 0; i < ENTRIES; i++) begin
            if (i < DFLT_COUNT) begin
                pad_map[i] = '{note: DFLT_NOTE[i], pad: DFLT_PAD[i], en: 1'b1};
            end else begin
                pad_map[i] = '0;
            end
        end
        map_fill = DFLT_COUNT;
    endfunction

    // update the first entry with this note, else append
    function automatic logic [1:0] place_note(input logic [6:0] nt, input logic signed [4:0] pd,
                                              output logic chg);
        chg = 1'b0;
        for (int i = 0; i < map_fill; i++) begin
            if (pad_map[i].note == nt) begin
                pad_map[i].pad = pd;
                pad_map[i].en  = !pd[4];
                chg = 1'b1;
                return ST_HIT;
            end
        end
        if (map_fill < ENTRIES) begin
            pad_map[map_fill] = '{note: nt, pad: pd, en: !pd[4]};
            map_fill++;
            chg = 1'b1;
            return ST_APPEND;
        end
        return ST_FULL;
    endfunction

    function automatic t_map_reply apply_request(input logic [2:0] rq, input logic [6:0] nt,
                                                 input logic signed [4:0] pd,
                                                 input logic [4:0] ix);
        t_map_reply r;
        bit hit;
        r.pad    = PAD_NONE;
        r.status = ST_NOMATCH;
        r.e_note = '0;
        r.e_pad  = PAD_NONE;
        r.e_en   = 1'b0;
        r.chg    = 1'b0;
        hit      = 0;
        case (rq)
            REQ_LOOKUP: begin
                for (int i = 0; i < map_fill; i++) begin
                    if (pad_map[i].note == nt && pad_map[i].en) begin
                        r.pad    = pad_map[i].pad;
                        r.status = ST_HIT;
                        break;
                    end
                end
            end
            REQ_SET_NOTE: begin
                r.status = place_note(nt, pd, r.chg);
            end
            REQ_SET_PAD: begin
                for (int i = 0; i < map_fill && i < MAIN_PADS; i++) begin
                    if (pad_map[i].pad == pd) begin
                        pad_map[i].note = nt;
                        pad_map[i].en   = 1'b1;
                        r.chg    = 1'b1;
                        r.status = ST_HIT;
                        hit      = 1;
                        break;
                    end
                end
                if (!hit) begin
                    r.status = place_note(nt, pd, r.chg);
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < map_fill; i++) begin
                    if (pad_map[i].note == nt) begin
                        pad_map[i].en = 1'b0;
                        r.chg    = 1'b1;
                        r.status = ST_HIT;
                        break;
                    end
                end
            end
            REQ_RESTORE: begin
                reset_map();
                r.chg    = 1'b1;
                r.status = ST_HIT;
            end
            REQ_READ: begin
                if (ix < map_fill) begin
                    r.e_note = pad_map[ix].note;
                    r.e_pad  = pad_map[ix].pad;
                    r.e_en   = pad_map[ix].en;
                    r.status = ST_HIT;
                end
            end
            default: begin
            end
        endcase
        r.count = 6'(map_fill);
        return r;
    endfunction

    task automatic add_req(input logic [2:0] rq, input logic [6:0] nt, input logic signed [4:0] pd,
                           input logic [4:0] ix, input bit dr);
        t_map_req m;
        m.req   = rq;
        m.note  = nt;
        m.pad   = pd;
        m.idx   = ix;
        m.gap   = tx_calm ? 0 : $urandom_range(0, 9);
        m.drain = dr;
        pending_reqs.push_back(m);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_err++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            wait_cnt = 0;
        end else begin
            tx_done = in_valid && !o_in_stall;
            if (tx_done) begin
                expected_replies.push_back(apply_request(in_req, in_note, in_pad, in_idx));
                n_put <= n_put + 1;
            end
            if (!in_valid || tx_done) begin
                if (pending_reqs.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (wait_cnt < pending_reqs[0].gap) begin
                    wait_cnt++;
                    in_valid <= 1'b0;
                end else if (pending_reqs[0].drain && (n_put + tx_done) != n_got) begin
                    in_valid <= 1'b0;
                end else begin
                    in_req   <= pending_reqs[0].req;
                    in_note  <= pending_reqs[0].note;
                    in_pad   <= pending_reqs[0].pad;
                    in_idx   <= pending_reqs[0].idx;
                    in_valid <= 1'b1;
                    void'(pending_reqs.pop_front());
                    wait_cnt = 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_map_reply e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("result transaction with no request pending");
                    n_err++;
                end else begin
                    e = expected_replies.pop_front();
                    check_field("pad_out", int'(e.pad), int'(o_pad_out));
                    check_field("status", int'(e.status), int'(o_status));
                    check_field("entry_note", int'(e.e_note), int'(o_entry_note));
                    check_field("entry_pad", int'(e.e_pad), int'(o_entry_pad));
                    check_field("entry_enabled", int'(e.e_en), int'(o_entry_enabled));
                    check_field("table_count", int'(e.count), int'(o_table_count));
                    check_field("changed", int'(e.chg), int'(o_changed));
                end
                n_got <= n_got + 1;
                if ($urandom_range(0, 29) == 0) begin
                    rx_calm = !rx_calm;
                end
                hold_left = rx_calm ? 0 : $urandom_range(0, 9);
            end else if (o_out_valid && hold_left > 0) begin
                hold_left--;
            end
            out_stall <= (hold_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int r;
        logic [2:0]        rq;
        logic [6:0]        nt;
        logic signed [4:0] pd;
        logic [4:0]        ix;
        bit                dr;
        reset_map();

        // directed part
        add_req(REQ_LOOKUP, 7'd36, 5'sd0, 5'd0, 0);
        add_req(REQ_LOOKUP, 7'd127, 5'sd0, 5'd31, 0);
        add_req(REQ_READ, 7'd0, 5'sd0, 5'd0, 0);
        add_req(REQ_READ, 7'd0, 5'sd0, 5'd23, 0);
        add_req(REQ_READ, 7'd0, 5'sd0, 5'd24, 0);
        add_req(REQ_SET_NOTE, 7'd36, 5'sd15, 5'd0, 0);
        add_req(REQ_SET_NOTE, 7'd127, PAD_NONE, 5'd0, 0);
        add_req(REQ_SET_NOTE, 7'd0, 5'sd0, 5'd0, 0);
        add_req(REQ_LOOKUP, 7'd127, 5'sd0, 5'd0, 0);
        add_req(REQ_SET_PAD, 7'd100, 5'sd3, 5'd0, 0);
        add_req(REQ_SET_PAD, 7'd101, PAD_NONE, 5'd0, 0);
        add_req(REQ_SET_PAD, 7'd102, 5'b10000, 5'd0, 0);
        add_req(REQ_CLEAR, 7'd38, 5'sd0, 5'd0, 0);
        add_req(REQ_CLEAR, 7'd120, 5'sd0, 5'd0, 0);
        add_req(REQ_LOOKUP, 7'd38, 5'sd0, 5'd0, 0);
        add_req(REQ_SET_NOTE, 7'd38, 5'sd7, 5'd0, 0);
        add_req(REQ_SPARE_A, 7'd36, 5'sd1, 5'd1, 0);
        add_req(REQ_SPARE_B, 7'd127, PAD_NONE, 5'd31, 0);
        for (int i = 0; i < 4; i++) begin
            add_req(REQ_SET_NOTE, 7'(110 + i), 5'(i), 5'd0, 0);
        end
        add_req(REQ_SET_NOTE, 7'd120, 5'sd5, 5'd0, 0);
        add_req(REQ_SET_PAD, 7'd121, 5'b11000, 5'd0, 0);
        add_req(REQ_READ, 7'd0, 5'sd0, 5'd31, 1);
        add_req(REQ_RESTORE, 7'd0, 5'sd0, 5'd0, 0);
        add_req(REQ_READ, 7'd0, 5'sd0, 5'd24, 0);

        // random part
        for (int k = 0; k < RANDOM_REQS; k++) begin
            r  = $urandom_range(0, 99);
            nt = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(33, 76))
                                             : 7'($urandom_range(0, 127));
            pd = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 16) - 1) : 5'($urandom);
            ix = 5'($urandom_range(0, 31));
            if (r < 24) begin
                rq = REQ_LOOKUP;
            end else if (r < 45) begin
                rq = REQ_SET_NOTE;
            end else if (r < 60) begin
                rq = REQ_SET_PAD;
            end else if (r < 72) begin
                rq = REQ_CLEAR;
            end else if (r < 92) begin
                rq = REQ_READ;
            end else if (r < 95) begin
                rq = REQ_RESTORE;
            end else if (r < 98) begin
                rq = REQ_SPARE_A;
            end else begin
                rq = REQ_SPARE_B;
            end
            dr = ($urandom_range(0, 59) == 0) || (k == RANDOM_REQS / 2);
            if ($urandom_range(0, 24) == 0) begin
                tx_calm = !tx_calm;
            end
            add_req(rq, nt, pd, ix, dr);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid || expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0 && expected_replies.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
